[design/wavdf_pkg.sv]
package wavdf_pkg;

    localparam int HEADER_BYTES = 44;
    localparam int HPOS_W       = 6;

    localparam logic [15:0] DAC_ZERO_RESET = 16'h8000;

    // Header byte positions of the captured fields
    localparam logic [HPOS_W-1:0] POS_CHANNELS = HPOS_W'(22);
    localparam logic [HPOS_W-1:0] POS_RATE_LO  = HPOS_W'(24);
    localparam logic [HPOS_W-1:0] POS_RATE_HI  = HPOS_W'(25);
    localparam logic [HPOS_W-1:0] POS_ALIGN    = HPOS_W'(32);
    localparam logic [HPOS_W-1:0] POS_BITS     = HPOS_W'(34);
    localparam logic [HPOS_W-1:0] POS_SIZE_LO  = HPOS_W'(40);
    localparam logic [HPOS_W-1:0] POS_SIZE_HI  = HPOS_W'(HEADER_BYTES - 1);
    localparam logic [HPOS_W-1:0] POS_LAST     = HPOS_W'(HEADER_BYTES - 1);

    // Tag failure flag bits
    localparam logic [3:0] TAG_NONE = 4'b0000;
    localparam logic [3:0] TAG_RIFF = 4'b0001;
    localparam logic [3:0] TAG_WAVE = 4'b0010;
    localparam logic [3:0] TAG_FMT  = 4'b0100;
    localparam logic [3:0] TAG_DATA = 4'b1000;

    // Header status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RIFF_BAD = 3'd1;
    localparam logic [2:0] ST_WAVE_BAD = 3'd2;
    localparam logic [2:0] ST_FMT_BAD  = 3'd3;
    localparam logic [2:0] ST_DATA_BAD = 3'd4;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PAIR   = 1'b1;

    localparam logic [7:0] STEREO_CHANNELS = 8'd2;
    localparam logic [7:0] MIN_ALIGN       = 8'd2;

    // ASCII codes of the tag characters
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_I  = 8'h49;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_W  = 8'h57;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_V  = 8'h56;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_LM = 8'h6D;
    localparam logic [7:0] CH_LT = 8'h74;
    localparam logic [7:0] CH_LD = 8'h64;
    localparam logic [7:0] CH_LA = 8'h61;

    typedef enum logic [2:0] {
        MODE_HEADER = 3'b001,
        MODE_DATA   = 3'b010,
        MODE_IDLE   = 3'b100
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  header_status;
        logic [15:0] sample_rate;
        logic [7:0]  channel_count;
        logic [7:0]  block_bytes;
        logic [7:0]  sample_bits;
        logic [31:0] data_bytes;
        logic [15:0] left_sample;
        logic [15:0] right_sample;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [3:0] flag;
        logic [7:0] want;
    } tag_check_t;

    // Expected tag byte at a header position; flag is empty where no tag is checked.
    function automatic tag_check_t tag_expect(input logic [HPOS_W-1:0] pos);
        tag_check_t t;
        t.flag = TAG_NONE;
        t.want = 8'h00;
        case (pos)
            6'd0:    begin t.flag = TAG_RIFF; t.want = CH_R;  end
            6'd1:    begin t.flag = TAG_RIFF; t.want = CH_I;  end
            6'd2:    begin t.flag = TAG_RIFF; t.want = CH_F;  end
            6'd3:    begin t.flag = TAG_RIFF; t.want = CH_F;  end
            6'd8:    begin t.flag = TAG_WAVE; t.want = CH_W;  end
            6'd9:    begin t.flag = TAG_WAVE; t.want = CH_A;  end
            6'd10:   begin t.flag = TAG_WAVE; t.want = CH_V;  end
            6'd11:   begin t.flag = TAG_WAVE; t.want = CH_E;  end
            6'd12:   begin t.flag = TAG_FMT;  t.want = CH_LF; end
            6'd13:   begin t.flag = TAG_FMT;  t.want = CH_LM; end
            6'd14:   begin t.flag = TAG_FMT;  t.want = CH_LT; end
            6'd36:   begin t.flag = TAG_DATA; t.want = CH_LD; end
            6'd37:   begin t.flag = TAG_DATA; t.want = CH_LA; end
            6'd38:   begin t.flag = TAG_DATA; t.want = CH_LT; end
            6'd39:   begin t.flag = TAG_DATA; t.want = CH_LA; end
            default: begin t.flag = TAG_NONE; t.want = 8'h00; end
        endcase
        return t;
    endfunction

endpackage

[design/wavdf_in_if.sv]
interface wavdf_in_if;
    import wavdf_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/wavdf_out_if.sv]
interface wavdf_out_if;
    import wavdf_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/wav_pcm16_stream_deframer_top.sv]
// WAV PCM16 stream deframer. The block takes a WAV file one byte per input
// transaction, one byte every clock cycle unless a held result stalls it,
// with each result in the cycle after its byte. A byte with start_of_file set
// restarts parsing as header byte 0; after reset the first byte is taken as
// header byte 0 as well. The 44-byte canonical header is checked for the
// RIFF, WAVE, fmt and data tags, and on its last byte a single status result
// (result_kind 0) reports the first failing tag together with the captured
// sample rate, channel count, block align, bits per sample and data size.
// After a good header with a non-zero data size, data bytes are grouped into
// blocks of block align bytes (values below 2 count as 2); each block, and a
// final partial block, gives one sample pair result (result_kind 1) whose
// samples have dac_zero added modulo 65536. Missing bytes count as zero, and
// the right sample repeats the left unless the file has two channels. The
// pair that completes the data size carries last; further bytes, and all
// bytes after a bad header, are ignored until the next start_of_file. The
// rate of one byte per cycle is set by the single state update per byte,
// whose longest path is the 32-bit data byte count increment and compare.
// dac_zero resets to 32768 and should only be written while the block is
// idle.
module wav_pcm16_stream_deframer_top
(
    input  logic               clk,
    input  logic               rst_n,
    wavdf_in_if.sink           in_ch,
    wavdf_out_if.source        out_ch,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);
    import wavdf_pkg::*;

    // Configuration
    logic [15:0] dac_zero_reg;

    // Parser state
    parse_mode_t       mode_reg,     mode_next;
    logic [HPOS_W-1:0] hpos_reg,     hpos_next;
    logic [3:0]        flags_reg,    flags_next;
    logic [15:0]       rate_reg,     rate_next;
    logic [7:0]        channels_reg, channels_next;
    logic [7:0]        align_reg,    align_next;
    logic [7:0]        bits_reg,     bits_next;
    logic [31:0]       size_reg,     size_next;
    logic [31:0]       count_reg,    count_next;
    logic [7:0]        bpos_reg,     bpos_next;
    logic [15:0]       left_reg,     left_next;
    logic [15:0]       right_reg,    right_next;

    // Result register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg,  out_item_next;

    logic       accept;
    logic       emit;
    tag_check_t tag;

    // Working values of the data path
    parse_mode_t       eff_mode;
    logic [HPOS_W-1:0] eff_hpos;
    logic [3:0]        eff_flags;
    logic [7:0]        byte_in;
    logic [7:0]        align_eff;
    logic [8:0]        bpos_inc;
    logic              block_end;
    logic              done;
    logic [2:0]        status;
    logic [15:0]       left_out;
    logic [15:0]       right_out;

    // The result register is free when empty or when its transaction
    // completes in this cycle, so a byte can enter every cycle.
    assign in_ch.ready    = !out_valid_reg || out_ch.ready;
    assign accept         = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    always_comb
    begin
        byte_in = in_ch.payload.data_byte;

        // A start flag restarts the header parse for this very byte. The
        // captured fields and block counters are all rewritten before use.
        if (in_ch.payload.start_of_file)
        begin
            eff_mode  = MODE_HEADER;
            eff_hpos  = '0;
            eff_flags = '0;
        end
        else
        begin
            eff_mode  = mode_reg;
            eff_hpos  = hpos_reg;
            eff_flags = flags_reg;
        end

        mode_next     = eff_mode;
        hpos_next     = eff_hpos;
        flags_next    = eff_flags;
        rate_next     = rate_reg;
        channels_next = channels_reg;
        align_next    = align_reg;
        bits_next     = bits_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        bpos_next     = bpos_reg;
        left_next     = left_reg;
        right_next    = right_reg;

        emit          = 1'b0;
        out_item_next = '0;

        tag       = tag_expect(eff_hpos);
        align_eff = (align_reg < MIN_ALIGN) ? MIN_ALIGN : align_reg;
        bpos_inc  = {1'b0, bpos_reg} + 9'd1;
        block_end = 1'b0;
        done      = 1'b0;
        status    = ST_OK;
        left_out  = '0;
        right_out = '0;

        unique case (eff_mode)
            MODE_HEADER:
            begin
                if (tag.flag != TAG_NONE && byte_in != tag.want)
                begin
                    flags_next = eff_flags | tag.flag;
                end
                if (eff_hpos == POS_CHANNELS)
                begin
                    channels_next = byte_in;
                end
                if (eff_hpos == POS_RATE_LO)
                begin
                    rate_next[7:0] = byte_in;
                end
                if (eff_hpos == POS_RATE_HI)
                begin
                    rate_next[15:8] = byte_in;
                end
                if (eff_hpos == POS_ALIGN)
                begin
                    align_next = byte_in;
                end
                if (eff_hpos == POS_BITS)
                begin
                    bits_next = byte_in;
                end
                if (eff_hpos >= POS_SIZE_LO && eff_hpos <= POS_SIZE_HI)
                begin
                    unique case (eff_hpos[1:0])
                        2'd0: size_next[7:0]   = byte_in;
                        2'd1: size_next[15:8]  = byte_in;
                        2'd2: size_next[23:16] = byte_in;
                        2'd3: size_next[31:24] = byte_in;
                    endcase
                end

                priority if (flags_next[0]) status = ST_RIFF_BAD;
                else if (flags_next[1])     status = ST_WAVE_BAD;
                else if (flags_next[2])     status = ST_FMT_BAD;
                else if (flags_next[3])     status = ST_DATA_BAD;
                else                        status = ST_OK;

                if (eff_hpos == POS_LAST)
                begin
                    emit                        = 1'b1;
                    out_item_next.result_kind   = KIND_STATUS;
                    out_item_next.header_status = status;
                    out_item_next.sample_rate   = rate_next;
                    out_item_next.channel_count = channels_next;
                    out_item_next.block_bytes   = align_next;
                    out_item_next.sample_bits   = bits_next;
                    out_item_next.data_bytes    = size_next;
                    mode_next  = (status != ST_OK || size_next == '0) ? MODE_IDLE
                                                                       : MODE_DATA;
                    hpos_next  = '0;
                    count_next = '0;
                    bpos_next  = '0;
                    left_next  = '0;
                    right_next = '0;
                end
                else
                begin
                    hpos_next = eff_hpos + HPOS_W'(1);
                end
            end

            MODE_DATA:
            begin
                // The first byte of a block clears both staging words.
                if (bpos_reg == 8'd0)
                begin
                    left_next  = {8'h00, byte_in};
                    right_next = '0;
                end
                else if (bpos_reg == 8'd1)
                begin
                    left_next[15:8] = byte_in;
                end
                else if (bpos_reg == 8'd2)
                begin
                    right_next[7:0] = byte_in;
                end
                else if (bpos_reg == 8'd3)
                begin
                    right_next[15:8] = byte_in;
                end

                count_next = count_reg + 32'd1;
                done       = (count_next >= size_reg);
                block_end  = (bpos_inc >= {1'b0, align_eff});
                bpos_next  = (block_end || done) ? 8'd0 : bpos_inc[7:0];

                left_out  = left_next + dac_zero_reg;
                right_out = (channels_reg == STEREO_CHANNELS) ? (right_next + dac_zero_reg)
                                                              : left_out;

                if (block_end || done)
                begin
                    emit                       = 1'b1;
                    out_item_next.result_kind  = KIND_PAIR;
                    out_item_next.left_sample  = left_out;
                    out_item_next.right_sample = right_out;
                    out_item_next.last         = done;
                end
                if (done)
                begin
                    mode_next = MODE_IDLE;
                end
            end

            MODE_IDLE:
            begin
                mode_next = MODE_IDLE;
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (accept)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ch.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_zero_reg  <= DAC_ZERO_RESET;
            mode_reg      <= MODE_HEADER;
            hpos_reg      <= '0;
            flags_reg     <= '0;
            rate_reg      <= '0;
            channels_reg  <= '0;
            align_reg     <= '0;
            bits_reg      <= '0;
            size_reg      <= '0;
            count_reg     <= '0;
            bpos_reg      <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dac_zero_reg <= cfg_wdata;
            end
            if (accept)
            begin
                mode_reg     <= mode_next;
                hpos_reg     <= hpos_next;
                flags_reg    <= flags_next;
                rate_reg     <= rate_next;
                channels_reg <= channels_next;
                align_reg    <= align_next;
                bits_reg     <= bits_next;
                size_reg     <= size_next;
                count_reg    <= count_next;
                bpos_reg     <= bpos_next;
                left_reg     <= left_next;
                right_reg    <= right_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // The result payload needs no reset; it is qualified by its valid flag.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

[design/wavdf_checker.sv]
module wavdf_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input wavdf_pkg::in_item_t   in_item,
    input logic                  out_valid,
    input logic                  out_ready,
    input wavdf_pkg::out_item_t  out_item
);
    import wavdf_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // The input side is never blocked by an empty result register.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // A result appears only after an accepted input transaction.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
        else $error("result without input transaction");

    // The first byte of a new file never produces a result.
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.start_of_file |=> !out_valid)
        else $error("result on start of file byte");

endmodule

bind wav_pcm16_stream_deframer_top wavdf_checker u_wavdf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_ch.payload),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
);
